@@ hw/rtl/olid_pkg.sv @@
package olid_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int DATA_W       = 32;
   localparam int KIND_W       = 3;
   localparam int POS_W        = 8;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 5;
   // length as seen by the controller; wide enough for any capacity in range
   localparam int LEN_FIELD_W  = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT_FRONT = 3'd0,
      KIND_DELETE_FRONT = 3'd1,
      KIND_DELETE_BACK  = 3'd2,
      KIND_DELETE_POS   = 3'd3,
      KIND_DELETE_KEY   = 3'd4,
      KIND_READ_OUT     = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_EMPTY  = 3'd1,
      STATUS_BADPOS = 3'd2,
      STATUS_NOKEY  = 3'd3,
      STATUS_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_INSERT,
      DP_DELETE_FRONT,
      DP_DELETE_BACK,
      DP_DELETE_POS,
      DP_DELETE_KEY,
      DP_ROTATE
   } dp_op_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] key;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       entry_count;
      logic signed [DATA_W-1:0] entry_value;
      logic                     last;
   } rsp_word_type;

   typedef struct packed {
      dp_op_type  op;
      logic       match_load;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_read;
      logic       rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic                   empty;
      logic                   full;
      logic                   pos_ok;
      logic                   key_found;
      logic [LEN_FIELD_W-1:0] length;
   } dp_status_type;

endpackage

@@ hw/rtl/olid_datapath.sv @@
module olid_datapath #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  olid_pkg::req_word_type  req_word,
   input  olid_pkg::dp_cmd_type    cmd,
   output olid_pkg::dp_status_type status,
   output olid_pkg::rsp_word_type  rsp_word
);
   import olid_pkg::*;

   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int LVL   = $clog2(CAPACITY);

   logic signed [DATA_W-1:0] entries_ff [CAPACITY];
   logic signed [DATA_W-1:0] entries_in [CAPACITY];
   logic [LEN_W-1:0]         length_ff, length_in;
   logic [CAPACITY-1:0]      match_ff, match_in;
   logic [CAPACITY-1:0]      pos_mask, key_mask;
   rsp_word_type             rsp_ff, rsp_in;
   logic [31:0]              len_ext;

   // key mask: bit i set when any match at or below i (log-step prefix OR)
   always_comb begin
      key_mask = match_ff;
      for (int l = 0; l < LVL; l++) begin
         key_mask = key_mask | (key_mask << (1 << l));
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
      logic signed [DATA_W-1:0] up, dn;
      logic                     is_tail, below_tail;

      if (i < CAPACITY - 1) begin : g_up
         assign up = entries_ff[i+1];
      end else begin : g_up_end
         assign up = entries_ff[i];
      end
      if (i > 0) begin : g_dn
         assign dn = entries_ff[i-1];
      end else begin : g_dn_head
         assign dn = req_word.value;
      end

      assign pos_mask[i] = ((POS_W+1)'(i + 1) >= {1'b0, req_word.position});
      assign is_tail     = (LEN_W'(i + 1) == length_ff);
      assign below_tail  = (LEN_W'(i + 1) < length_ff);
      assign match_in[i] = (entries_ff[i] == req_word.key) && (LEN_W'(i) < length_ff);

      always_comb begin
         unique case (cmd.op)
            DP_INSERT:       entries_in[i] = dn;
            DP_DELETE_FRONT: entries_in[i] = up;
            DP_DELETE_POS:   entries_in[i] = pos_mask[i] ? up : entries_ff[i];
            DP_DELETE_KEY:   entries_in[i] = key_mask[i] ? up : entries_ff[i];
            // rotate within the held entries; head wraps to the tail
            DP_ROTATE:       entries_in[i] = is_tail ? entries_ff[0] :
                                             (below_tail ? up : entries_ff[i]);
            default:         entries_in[i] = entries_ff[i];
         endcase
      end
   end

   always_comb begin
      unique case (cmd.op)
         DP_INSERT:       length_in = LEN_W'(length_ff + 1'b1);
         DP_DELETE_FRONT,
         DP_DELETE_BACK,
         DP_DELETE_POS,
         DP_DELETE_KEY:   length_in = LEN_W'(length_ff - 1'b1);
         default:         length_in = length_ff;
      endcase
   end

   assign len_ext = 32'(length_in);

   always_comb begin
      rsp_in             = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.status      = cmd.rsp_status;
         rsp_in.entry_count = len_ext[COUNT_W-1:0];
         rsp_in.entry_value = cmd.rsp_read ? entries_ff[0] : '0;
         rsp_in.last        = cmd.rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
      if (cmd.match_load) begin
         match_ff <= match_in;
      end
   end

   assign status.empty     = (length_ff == '0);
   assign status.full      = (length_ff == LEN_W'(CAPACITY));
   assign status.pos_ok    = (req_word.position != '0) &&
                             ({1'b0, req_word.position} <= (POS_W+1)'(length_ff));
   assign status.key_found = |match_ff;
   assign status.length    = LEN_FIELD_W'(length_ff);
   assign rsp_word         = rsp_ff;

endmodule

@@ hw/rtl/olid_controller.sv @@
module olid_controller #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [olid_pkg::KIND_W-1:0] req_kind,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  olid_pkg::dp_status_type status,
   output olid_pkg::dp_cmd_type    cmd
);
   import olid_pkg::*;

   localparam int LEN_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEY,
      ST_READ
   } state_type;

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   slot_free, accept;
   logic [LEN_FIELD_W-1:0] cnt_ext, cnt_nxt, rd_limit;
   logic                   rd_emit, rd_last, rd_done;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;

   assign cnt_ext  = LEN_FIELD_W'(cnt_ff);
   assign cnt_nxt  = LEN_FIELD_W'(cnt_ext + 1'b1);
   assign rd_limit = (status.length < LEN_FIELD_W'(RESULT_LIMIT)) ?
                     status.length : LEN_FIELD_W'(RESULT_LIMIT);
   assign rd_emit  = (cnt_ext < rd_limit);
   assign rd_last  = (cnt_nxt == rd_limit);
   assign rd_done  = (cnt_nxt == status.length);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '{op: DP_IDLE, match_load: 1'b0, rsp_load: 1'b0,
                   rsp_status: STATUS_OK, rsp_read: 1'b0, rsp_last: 1'b1};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_INSERT_FRONT: begin
                     cmd.rsp_load = 1'b1;
                     if (status.full) cmd.rsp_status = STATUS_FULL;
                     else             cmd.op = DP_INSERT;
                  end
                  KIND_DELETE_FRONT: begin
                     cmd.rsp_load = 1'b1;
                     if (status.empty) cmd.rsp_status = STATUS_EMPTY;
                     else              cmd.op = DP_DELETE_FRONT;
                  end
                  KIND_DELETE_BACK: begin
                     cmd.rsp_load = 1'b1;
                     if (status.empty) cmd.rsp_status = STATUS_EMPTY;
                     else              cmd.op = DP_DELETE_BACK;
                  end
                  KIND_DELETE_POS: begin
                     cmd.rsp_load = 1'b1;
                     if (!status.pos_ok) cmd.rsp_status = STATUS_BADPOS;
                     else                cmd.op = DP_DELETE_POS;
                  end
                  KIND_DELETE_KEY: begin
                     if (status.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        cmd.match_load = 1'b1;
                        state_in       = ST_KEY;
                     end
                  end
                  KIND_READ_OUT: begin
                     if (status.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        cnt_in   = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: ; // undefined kinds are dropped
               endcase
            end
         end
         ST_KEY: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               if (status.key_found) cmd.op = DP_DELETE_KEY;
               else                  cmd.rsp_status = STATUS_NOKEY;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            // beyond the result limit the list keeps rotating, unseen
            if (slot_free || !rd_emit) begin
               cmd.op       = DP_ROTATE;
               cmd.rsp_load = rd_emit;
               cmd.rsp_read = 1'b1;
               cmd.rsp_last = rd_last;
               cnt_in       = LEN_W'(cnt_ff + 1'b1);
               if (rd_done) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load)    rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/ordered_list_insert_delete.sv @@
// channel  ports                            word            moves when
// req      req_valid req_stall req_word     kind/value/...  valid & !stall
// rsp      rsp_valid rsp_stall rsp_word     status/count/.. valid & !stall
//
// Insert and the position, front and back deletes finish in the accept cycle.
// Delete by key compares across all entries into a registered match mask, then shifts.
// Read-out rotates the entry array through every entry held and returns up to the first RESULT_LIMIT.
// Synchronous reset empties the list; entry contents are not cleared.
// A stalled result holds the output register and blocks further requests.
module ordered_list_insert_delete #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  olid_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output olid_pkg::rsp_word_type rsp_word
);
   import olid_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   olid_controller #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_word.kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   olid_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule
